/* src/swip_pkg.sv */
// Shared types and operation codes for the indexed-pop stack.
`default_nettype none
package swip_pkg;

    localparam int OP_W = 2;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 4;
    localparam int COUNT_OUT_W = 5;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_PUSH  = 2'd0;
    localparam t_op OP_POP   = 2'd1;
    localparam t_op OP_PEEK  = 2'd2;
    localparam t_op OP_CLEAR = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the incoming word
        logic execute;   // apply the latched operation to the stack
    } t_dp_cmd;

endpackage
`default_nettype wire

/* src/swip_ctrl.sv */
// Controller state machine: sequences capture, execute and result strobe.
`default_nettype none
module swip_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    output logic                  o_valid,
    output swip_pkg::t_dp_cmd     o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign busy    = (r_state == ST_EXEC);
    assign o_valid = (r_state == ST_DONE);
    assign accept  = start && !busy;

    assign o_cmd.capture = accept;
    assign o_cmd.execute = (r_state == ST_EXEC);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // take the next word while the result is on show
                n_state = accept ? ST_EXEC : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* src/swip_dp.sv */
// Datapath: stack register cells, count and result registers.
`default_nettype none
module swip_dp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire swip_pkg::t_dp_cmd                    i_cmd,
    input  wire swip_pkg::t_op                        i_op,
    input  wire logic [swip_pkg::VALUE_W-1:0]         i_value,
    input  wire logic [swip_pkg::INDEX_W-1:0]         i_depth_index,
    output logic [swip_pkg::VALUE_W-1:0]              o_read_word,
    output logic                                      o_found,
    output logic [swip_pkg::COUNT_OUT_W-1:0]          o_entry_count,
    output logic                                      o_overflow
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int AW   = $clog2(DEPTH);
    localparam int CMPW = (CW > swip_pkg::INDEX_W) ? CW : swip_pkg::INDEX_W;

    // Slot 0 is the bottom; slot count-1 is the top.
    logic [DATA_WIDTH-1:0]              r_cell [DEPTH];
    logic [CW-1:0]                      r_count;
    logic [CW-1:0]                      n_count;

    swip_pkg::t_op                      r_op;
    logic [DATA_WIDTH-1:0]              r_value;
    logic [swip_pkg::INDEX_W-1:0]       r_idx;

    logic [swip_pkg::VALUE_W-1:0]       r_read_word;
    logic                               r_found;
    logic                               r_overflow;

    logic                               is_push;
    logic                               is_pop;
    logic                               is_pp;
    logic                               full;
    logic                               hit;
    logic [CMPW-1:0]                    cnt_ext;
    logic [CMPW-1:0]                    idx_ext;
    logic [CMPW-1:0]                    pos_w;
    logic [AW-1:0]                      pos;
    logic [63:0]                        rd_ext;

    assign is_push = (r_op == swip_pkg::OP_PUSH);
    assign is_pop  = (r_op == swip_pkg::OP_POP);
    assign is_pp   = is_pop || (r_op == swip_pkg::OP_PEEK);
    assign full    = (r_count == CW'(DEPTH));
    assign cnt_ext = CMPW'(r_count);
    assign idx_ext = CMPW'(r_idx);
    assign hit     = is_pp && (idx_ext < cnt_ext);
    assign pos_w   = cnt_ext - CMPW'(1) - idx_ext;
    assign pos     = pos_w[AW-1:0];
    assign rd_ext  = 64'(r_cell[pos]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_value <= DATA_WIDTH'(i_value);
            r_idx   <= i_depth_index;
        end
    end

    // Each cell takes a pushed word or the word above it when the gap closes.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic push_here;
        logic shift_here;
        assign push_here  = is_push && !full && (r_count == CW'(k));
        assign shift_here = is_pop && hit && (CMPW'(k) >= pos_w)
                            && (CMPW'(k + 1) < cnt_ext);
        if (k < DEPTH - 1) begin : g_shift
            always_ff @(posedge i_clk) begin
                if (i_cmd.execute) begin
                    if (push_here) begin
                        r_cell[k] <= r_value;
                    end else if (shift_here) begin
                        r_cell[k] <= r_cell[k+1];
                    end
                end
            end
        end else begin : g_top
            always_ff @(posedge i_clk) begin
                if (i_cmd.execute && (push_here || shift_here)) begin
                    r_cell[k] <= r_value;
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        priority if (r_op == swip_pkg::OP_CLEAR) begin
            n_count = '0;
        end else if (is_push && !full) begin
            n_count = r_count + CW'(1);
        end else if (is_pop && hit) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_read_word <= hit ? rd_ext[swip_pkg::VALUE_W-1:0] : '0;
            r_found     <= hit;
            r_overflow  <= is_push && full;
        end
    end

    assign o_read_word   = r_read_word;
    assign o_found       = r_found;
    assign o_entry_count = swip_pkg::COUNT_OUT_W'(r_count);
    assign o_overflow    = r_overflow;

endmodule
`default_nettype wire

/* src/stack_with_indexed_pop_core.sv */
// Top level of the bounded stack with indexed pop and peek.
//
//  channel  | direction | handshake               | fields
//  ---------+-----------+-------------------------+-----------------------------------------
//  command  | in        | start high, busy low    | i_op, i_value, i_depth_index
//  result   | out       | o_valid, one cycle      | o_read_word, o_found, o_entry_count,
//           |           |                         | o_overflow
//
// Each word is executed on the register cells in the execute state, then its result
// is on show in the done state; a new word is taken while that result is on show.
// The cells above a removed entry all shift in the execute state, so a deep index
// takes no longer than a shallow one. Reset empties the stack at once.
// The receiver cannot stall; busy is high only in the execute cycle.
`default_nettype none
module stack_with_indexed_pop_core #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [swip_pkg::OP_W-1:0]            i_op,
    input  wire logic [swip_pkg::VALUE_W-1:0]         i_value,
    input  wire logic [swip_pkg::INDEX_W-1:0]         i_depth_index,
    output logic                                      o_valid,
    output logic [swip_pkg::VALUE_W-1:0]              o_read_word,
    output logic                                      o_found,
    output logic [swip_pkg::COUNT_OUT_W-1:0]          o_entry_count,
    output logic                                      o_overflow
);

    swip_pkg::t_dp_cmd cmd;

    swip_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    swip_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_op          (i_op),
        .i_value       (i_value),
        .i_depth_index (i_depth_index),
        .o_read_word   (o_read_word),
        .o_found       (o_found),
        .o_entry_count (o_entry_count),
        .o_overflow    (o_overflow)
    );

endmodule
`default_nettype wire

/* src/swip_chk.sv */
// Port-level checker for the stack core, bound to the top level.
`default_nettype none
module swip_chk (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 start,
    input wire logic                                 busy,
    input wire logic                                 o_valid,
    input wire logic [swip_pkg::VALUE_W-1:0]         o_read_word,
    input wire logic                                 o_found,
    input wire logic                                 o_overflow
);

    // An accepted word raises busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // Each execute cycle is followed by a result strobe, with busy low.
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_valid && !busy))
        else $error("no result after execute cycle");

    // A strobe only follows an execute cycle.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a word");

    // A missed lookup reads as zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_read_word == '0))
        else $error("nonzero word with found low");

    // Overflow and found never come together.
    a_ovf_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_overflow && o_found))
        else $error("overflow and found both set");

endmodule

bind stack_with_indexed_pop_core swip_chk u_swip_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_read_word (o_read_word),
    .o_found     (o_found),
    .o_overflow  (o_overflow)
);
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the indexed-pop stack: directed corners, then random command traffic.
module tb_top;
    import swip_pkg::*;

    localparam int STACK_DEPTH   = 16;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_GAP       = 40;

    typedef struct packed {
        logic [VALUE_W-1:0]     word;
        logic                   found;
        logic [COUNT_OUT_W-1:0] count;
        logic                   overflow;
    } t_stack_result;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   start         = 1'b0;
    t_op                    i_op          = OP_PUSH;
    logic [VALUE_W-1:0]     i_value       = '0;
    logic [INDEX_W-1:0]     i_depth_index = '0;
    logic                   busy;
    logic                   o_valid;
    logic [VALUE_W-1:0]     o_read_word;
    logic                   o_found;
    logic [COUNT_OUT_W-1:0] o_entry_count;
    logic                   o_overflow;

    // Predicted stack contents, slot 0 at the bottom
    logic [VALUE_W-1:0] model_cells [STACK_DEPTH];
    int unsigned        model_count = 0;
    t_stack_result      pending_results [$];
    int unsigned        n_words = 0, n_checked = 0, n_errors = 0;
    int unsigned        n_hits = 0, n_overflows = 0, n_full_seen = 0;
    int                 idle_pct = 25;

    stack_with_indexed_pop_core #(
        .DEPTH      (STACK_DEPTH),
        .DATA_WIDTH (VALUE_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_value       (i_value),
        .i_depth_index (i_depth_index),
        .o_valid       (o_valid),
        .o_read_word   (o_read_word),
        .o_found       (o_found),
        .o_entry_count (o_entry_count),
        .o_overflow    (o_overflow)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_stack_result apply_stack_op(t_op op, logic [VALUE_W-1:0] val,
                                                     logic [INDEX_W-1:0] idx);
        t_stack_result res;
        int unsigned   pos;
        res = '0;
        case (op)
            OP_PUSH: begin
                if (model_count >= STACK_DEPTH) begin
                    res.overflow = 1'b1;
                end else begin
                    model_cells[model_count] = val;
                    model_count++;
                end
            end
            OP_POP, OP_PEEK: begin
                if (idx < model_count) begin
                    pos       = model_count - 1 - idx;
                    res.word  = model_cells[pos];
                    res.found = 1'b1;
                    if (op == OP_POP) begin
                        // close the gap: everything above moves down one slot
                        for (int k = pos; k + 1 < model_count; k++)
                            model_cells[k] = model_cells[k + 1];
                        model_count--;
                    end
                end
            end
            default: begin
                model_count = 0;
            end
        endcase
        if (model_count == STACK_DEPTH)
            n_full_seen++;
        res.count = model_count[COUNT_OUT_W-1:0];
        return res;
    endfunction

    task automatic send_word(t_op op, logic [VALUE_W-1:0] val, logic [INDEX_W-1:0] idx);
        int gap;
        start         <= 1'b1;
        i_op          <= op;
        i_value       <= val;
        i_depth_index <= idx;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_stack_op(op, val, idx));
        n_words++;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off until every outstanding word has produced its result
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic void check_field(string name, logic [VALUE_W-1:0] want,
                                        logic [VALUE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_stack_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, expected none, actual %h/%b/%0d/%b",
                         $time, o_read_word, o_found, o_entry_count, o_overflow);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                n_hits      += want.found;
                n_overflows += want.overflow;
                check_field("read_word", want.word, o_read_word);
                check_field("found", VALUE_W'(want.found), VALUE_W'(o_found));
                check_field("entry_count", VALUE_W'(want.count), VALUE_W'(o_entry_count));
                check_field("overflow", VALUE_W'(want.overflow), VALUE_W'(o_overflow));
            end
        end
    end

    task automatic test_empty_reads();
        send_word(OP_CLEAR, $urandom, 4'd0);
        send_word(OP_PEEK, $urandom, 4'd0);
        send_word(OP_POP, $urandom, 4'd15);
    endtask

    task automatic test_fill_and_overflow();
        send_word(OP_PUSH, 32'h0000_0000, INDEX_W'($urandom_range(15)));
        send_word(OP_PUSH, 32'hFFFF_FFFF, INDEX_W'($urandom_range(15)));
        for (int i = 2; i < STACK_DEPTH; i++)
            send_word(OP_PUSH, (i[0] ? 32'h5555_5555 : 32'hAAAA_AAAA) ^ i, 4'd0);
        // stack is full now: this word must be dropped
        send_word(OP_PUSH, 32'hDEAD_0001, 4'd0);
    endtask

    task automatic test_indexed_remove();
        send_word(OP_PEEK, '0, 4'd15);
        send_word(OP_POP, '0, 4'd15);
        send_word(OP_POP, '0, 4'd0);
        send_word(OP_PEEK, '0, 4'd14);
        send_word(OP_CLEAR, '0, 4'd0);
    endtask

    task automatic test_random_traffic(int n_items, int idle, int push_pct);
        t_op               op;
        logic [INDEX_W-1:0] idx;
        int                r;
        idle_pct = idle;
        repeat (n_items) begin
            r = $urandom_range(99);
            if (r < 3)
                op = OP_CLEAR;
            else if (r < 3 + push_pct)
                op = OP_PUSH;
            else
                op = $urandom_range(1) ? OP_POP : OP_PEEK;
            // aim mostly at live entries, sometimes anywhere
            if (model_count > 0 && $urandom_range(99) < 75)
                idx = INDEX_W'($urandom_range(model_count - 1));
            else
                idx = INDEX_W'($urandom_range(15));
            send_word(op, $urandom, idx);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_reads();
        test_fill_and_overflow();
        test_indexed_remove();
        drain_results();
        test_random_traffic(300, 25, 55);
        drain_results();
        test_random_traffic(300, 87, 40);
        drain_results();
        test_random_traffic(300, 0, 50);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d words, %0d results checked: %0d pop/peek hits, %0d dropped pushes,",
                 n_words, n_checked, n_hits, n_overflows);
        $display("stack full %0d times, sender idling at 25, 87 and 0 percent.", n_full_seen);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
src/swip_pkg.sv
src/swip_ctrl.sv
src/swip_dp.sv
src/stack_with_indexed_pop_core.sv
src/swip_chk.sv
bench/tb_top.sv
